FILE: sv/integer_alu_with_power_factorial_unit_assert.svh
`ifndef INTEGER_ALU_WITH_POWER_FACTORIAL_UNIT_ASSERT_SVH
`define INTEGER_ALU_WITH_POWER_FACTORIAL_UNIT_ASSERT_SVH

// same-cycle implication
`define IALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/ialu_pkg.sv
`timescale 1ns / 1ps
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int OP_W           = 3;
    localparam int ST_W           = 2;
    localparam int IN_TDATA_W     = 72;
    localparam int OUT_TDATA_W    = 72;
    localparam int MUL_DIGIT      = 8;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_POW  = 3'd4;
    localparam logic [OP_W-1:0] OP_FACT = 3'd5;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV0    = 2'd1;
    localparam logic [ST_W-1:0] ST_NEGEXP  = 2'd2;
    localparam logic [ST_W-1:0] ST_NEGFACT = 2'd3;

    typedef logic [1:0] t_msel;
    localparam t_msel MSEL_AB     = 2'd0;
    localparam t_msel MSEL_ACC_SQ = 2'd1;
    localparam t_msel MSEL_SQ_SQ  = 2'd2;
    localparam t_msel MSEL_ACC_I  = 2'd3;

    typedef struct packed {
        logic      load;
        logic      mul_start;
        t_msel     mul_sel;
        logic      acc_ld;
        logic      sq_ld;
        logic      exp_shift;
        logic      i_inc;
        logic      div_step;
        logic      fin;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            mul_busy;
        logic            exp_zero;
        logic            exp_lsb;
        logic            exp_le1;
        logic            fact_end;
        logic            div_last;
    } t_stat;

endpackage

FILE: sv/ialu_ctrl.sv
`timescale 1ns / 1ps
module ialu_ctrl import ialu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MULW  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_POW   = 4'd4;
    localparam logic [3:0] S_POWM1 = 4'd5;
    localparam logic [3:0] S_POWSQ = 4'd6;
    localparam logic [3:0] S_POWM2 = 4'd7;
    localparam logic [3:0] S_FACT  = 4'd8;
    localparam logic [3:0] S_FACTM = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_ov, n_ov;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.err) begin
                    n_state = S_FIN;
                end else begin
                    case (i_stat.op)
                        OP_MUL: begin
                            o_cmd.mul_start = 1'b1;
                            o_cmd.mul_sel   = MSEL_AB;
                            n_state         = S_MULW;
                        end
                        OP_DIV:  n_state = S_DIV;
                        OP_POW:  n_state = S_POW;
                        OP_FACT: n_state = S_FACT;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_MULW: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.acc_ld = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_FIN;
            end
            S_POW: begin
                if (i_stat.exp_zero) begin
                    n_state = S_FIN;
                end else if (i_stat.exp_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_ACC_SQ;
                    n_state         = S_POWM1;
                end else begin
                    n_state = S_POWSQ;
                end
            end
            S_POWM1: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.acc_ld = 1'b1;
                    n_state      = S_POWSQ;
                end
            end
            S_POWSQ: begin
                o_cmd.exp_shift = 1'b1;
                if (i_stat.exp_le1) begin
                    n_state = S_POW;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_SQ_SQ;
                    n_state         = S_POWM2;
                end
            end
            S_POWM2: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.sq_ld = 1'b1;
                    n_state     = S_POW;
                end
            end
            S_FACT: begin
                if (i_stat.fact_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_ACC_I;
                    n_state         = S_FACTM;
                end
            end
            S_FACTM: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.acc_ld = 1'b1;
                    o_cmd.i_inc  = 1'b1;
                    n_state      = S_FACT;
                end
            end
            S_FIN: begin
                if (!r_ov || i_m_tready) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (o_cmd.fin) begin
            n_ov = 1'b1;
        end else if (i_m_tready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

endmodule

FILE: sv/ialu_dp.sv
`timescale 1ns / 1ps
module ialu_dp import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [FIELD_W-1:0] i_a,
    input  logic signed [FIELD_W-1:0] i_b,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    output logic [FIELD_W-1:0]        o_value,
    output logic [FIELD_W-1:0]        o_rem,
    output logic [ST_W-1:0]           o_status
);

    localparam int W      = DATA_WIDTH;
    localparam int MSTEPS = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MCW    = $clog2(MSTEPS + 1);
    localparam int DCW    = $clog2(W + 1);

    logic [OP_W-1:0] r_op;
    logic [ST_W-1:0] r_st;
    logic [W-1:0]    r_a, r_b, r_acc, r_sq, r_exp, r_i, r_rem;
    logic [DCW-1:0]  r_cnt;
    logic [W-1:0]    r_mx, r_my, r_mp;
    logic [MCW-1:0]  r_mcnt;
    logic            r_mbusy;
    logic [W-1:0]    r_value, r_remo;
    logic [ST_W-1:0] r_status;

    logic [W-1:0]           a_w, b_w, mag_a, mag_b;
    logic [ST_W-1:0]        st_ld;
    logic [W+MUL_DIGIT-1:0] pp;
    logic [W:0]             rr_sh, diff;
    logic [W-1:0]           q_s, r_s, res_v, res_r;

    assign a_w   = W'(i_a);
    assign b_w   = W'(i_b);
    assign mag_a = a_w[W-1] ? (W'(0) - a_w) : a_w;
    assign mag_b = b_w[W-1] ? (W'(0) - b_w) : b_w;

    always_comb begin
        st_ld = ST_OK;
        case (i_op)
            OP_DIV:  if (b_w == '0) st_ld = ST_DIV0;
            OP_POW:  if (b_w[W-1]) st_ld = ST_NEGEXP;
            OP_FACT: if (a_w[W-1]) st_ld = ST_NEGFACT;
            default: st_ld = ST_OK;
        endcase
    end

    assign pp    = r_mx * r_my[MUL_DIGIT-1:0];
    assign rr_sh = {r_rem, r_acc[W-1]};
    assign diff  = rr_sh - {1'b0, r_sq};

    assign q_s = (r_a[W-1] ^ r_b[W-1]) ? (W'(0) - r_acc) : r_acc;
    assign r_s = r_a[W-1] ? (W'(0) - r_rem) : r_rem;

    always_comb begin
        res_v = '0;
        res_r = '0;
        if (r_st == ST_OK) begin
            case (r_op) inside
                OP_ADD: res_v = r_a + r_b;
                OP_SUB: res_v = r_a - r_b;
                OP_MUL, OP_POW, OP_FACT: res_v = r_acc;
                OP_DIV: begin
                    res_v = q_s;
                    res_r = r_s;
                end
                default: res_v = '0;
            endcase
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.err      = (r_st != ST_OK);
    assign o_stat.mul_busy = r_mbusy;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.exp_le1  = (r_exp[W-1:1] == '0);
    assign o_stat.fact_end = (r_i > r_a) || (r_acc == '0);
    assign o_stat.div_last = (r_cnt == DCW'(1));

    assign o_value  = FIELD_W'(r_value);
    assign o_rem    = FIELD_W'(r_remo);
    assign o_status = r_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_st  <= st_ld;
            r_a   <= a_w;
            r_b   <= b_w;
            r_exp <= b_w;
            r_i   <= W'(1);
            r_rem <= '0;
            r_cnt <= DCW'(W);
            if (i_op == OP_DIV) begin
                r_acc <= mag_a;
                r_sq  <= mag_b;
            end else begin
                r_acc <= W'(1);
                r_sq  <= a_w;
            end
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DCW'(1);
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_acc <= {r_acc[W-2:0], 1'b1};
            end else begin
                r_rem <= rr_sh[W-1:0];
                r_acc <= {r_acc[W-2:0], 1'b0};
            end
        end
        if (i_cmd.acc_ld) r_acc <= r_mp;
        if (i_cmd.sq_ld) r_sq <= r_mp;
        if (i_cmd.exp_shift) r_exp <= r_exp >> 1;
        if (i_cmd.i_inc) r_i <= r_i + W'(1);
        if (i_cmd.mul_start) begin
            r_mp   <= '0;
            r_mcnt <= MCW'(MSTEPS);
            case (i_cmd.mul_sel)
                MSEL_AB: begin
                    r_mx <= r_a;
                    r_my <= r_b;
                end
                MSEL_ACC_SQ: begin
                    r_mx <= r_acc;
                    r_my <= r_sq;
                end
                MSEL_SQ_SQ: begin
                    r_mx <= r_sq;
                    r_my <= r_sq;
                end
                default: begin
                    r_mx <= r_acc;
                    r_my <= r_i;
                end
            endcase
        end else if (r_mbusy) begin
            r_mp   <= r_mp + pp[W-1:0];
            r_mx   <= r_mx << MUL_DIGIT;
            r_my   <= r_my >> MUL_DIGIT;
            r_mcnt <= r_mcnt - MCW'(1);
        end
        if (i_cmd.fin) begin
            r_value  <= res_v;
            r_remo   <= res_r;
            r_status <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && r_mcnt == MCW'(1)) begin
            r_mbusy <= 1'b0;
        end
    end

endmodule

FILE: sv/integer_alu_with_power_factorial_unit.sv
// Throughput: one transaction at a time, bound by the 8-bit-per-cycle shared multiplier
// and the 1-bit-per-cycle restoring divider; a result may wait while the next is taken.
// Reset: synchronous, active low; clears the controller, the output valid flag and the multiplier busy flag.
`timescale 1ns / 1ps
module integer_alu_with_power_factorial_unit import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // operation, operand_a, operand_b
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata   // value, remainder_value, status
);

    t_cmd                cmd;
    t_stat               stat;
    logic [FIELD_W-1:0]  value, rem;
    logic [ST_W-1:0]     status;

    ialu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ialu_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (i_s_tdata[OP_W-1:0]),
        .i_a      (i_s_tdata[OP_W+FIELD_W-1:OP_W]),
        .i_b      (i_s_tdata[OP_W+2*FIELD_W-1:OP_W+FIELD_W]),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_value  (value),
        .o_rem    (rem),
        .o_status (status)
    );

    assign o_m_tdata = {(OUT_TDATA_W - 2*FIELD_W - ST_W)'(0), status, rem, value};

`include "integer_alu_with_power_factorial_unit_assert.svh"

    `IALU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `IALU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_m_tvalid && status != ST_OK, value == '0 && rem == '0)
    `IALU_ASSERT_IMP(a_valid_from_busy, i_clk, i_rst_n, $rose(o_m_tvalid), $past(!o_s_tready))

endmodule
